/* rtl/core/qmr_pkg.sv */
// qmr_pkg: shared types and constants for the quadratic minimum-root unit.
// No dependencies; used by the cells, the top level and the checker.
package qmr_pkg;

	localparam int COEF_W  = 32;
	localparam int ROOT_W  = 48;
	localparam int MISS_W  = 47;
	localparam int E_W     = 64;  // discriminant quarter width
	localparam int SQ_N    = 32;  // square root cells, one root bit each
	localparam int SQ_RW   = 36;  // square root partial remainder
	localparam int NUM_W   = 33;  // numerator magnitude
	localparam int DEN_W   = 33;  // divisor magnitude |2a|
	localparam int DIV_RW  = 34;  // divider partial remainder

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOROOT = 2'd1;
	localparam logic [1:0] ST_AZERO  = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	typedef struct packed {
		logic signed [COEF_W-1:0] a;
		logic signed [COEF_W-1:0] b;
		logic                     rem;   // low bit of b*b
		logic [1:0]               code;
	} sq_side_t;

	typedef struct packed {
		logic       neg;
		logic [1:0] code;
	} dv_side_t;

endpackage

/* rtl/core/qmr_sqrt_cell.sv */
// qmr_sqrt_cell: one step of the digit-by-digit integer square root.
// Depends on qmr_pkg.
module qmr_sqrt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  logic [qmr_pkg::E_W-1:0]       e_in,
	input  logic [qmr_pkg::SQ_RW-1:0]     r_in,
	input  logic [qmr_pkg::SQ_N-1:0]      g_in,
	input  qmr_pkg::sq_side_t             side_in,
	output logic                          v_q,
	output logic [qmr_pkg::E_W-1:0]       e_q,
	output logic [qmr_pkg::SQ_RW-1:0]     r_q,
	output logic [qmr_pkg::SQ_N-1:0]      g_q,
	output qmr_pkg::sq_side_t             side_q
);

	logic [qmr_pkg::SQ_RW-1:0] r_t;
	logic [qmr_pkg::SQ_RW-1:0] trial;
	logic                      take;

	assign r_t   = {r_in[qmr_pkg::SQ_RW-3:0], e_in[qmr_pkg::E_W-1 -: 2]};
	assign trial = {{(qmr_pkg::SQ_RW-qmr_pkg::SQ_N-2){1'b0}}, g_in, 2'b01};
	assign take  = (r_t >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_q    <= {e_in[qmr_pkg::E_W-3:0], 2'b00};
			r_q    <= take ? (r_t - trial) : r_t;
			g_q    <= {g_in[qmr_pkg::SQ_N-2:0], take};
			side_q <= side_in;
		end
	end

endmodule

/* rtl/core/qmr_div_cell.sv */
// qmr_div_cell: one restoring-division step, one quotient bit per cell.
// Depends on qmr_pkg.
module qmr_div_cell #(
	parameter int QW = 49
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  logic [QW-1:0]                  dvd_in,
	input  logic [qmr_pkg::DEN_W-1:0]      den_in,
	input  logic [qmr_pkg::DIV_RW-1:0]     r_in,
	input  logic [QW-1:0]                  q_in,
	input  qmr_pkg::dv_side_t              side_in,
	output logic                           v_q,
	output logic [QW-1:0]                  dvd_q,
	output logic [qmr_pkg::DEN_W-1:0]      den_q,
	output logic [qmr_pkg::DIV_RW-1:0]     r_q,
	output logic [QW-1:0]                  q_q,
	output qmr_pkg::dv_side_t              side_q
);

	logic [qmr_pkg::DIV_RW-1:0] r_t;
	logic [qmr_pkg::DIV_RW-1:0] dx;
	logic                       take;

	assign r_t  = {r_in[qmr_pkg::DIV_RW-2:0], dvd_in[QW-1]};
	assign dx   = {{(qmr_pkg::DIV_RW-qmr_pkg::DEN_W){1'b0}}, den_in};
	assign take = (r_t >= dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_q  <= {dvd_in[QW-2:0], 1'b0};
			den_q  <= den_in;
			r_q    <= take ? (r_t - dx) : r_t;
			q_q    <= {q_in[QW-2:0], take};
			side_q <= side_in;
		end
	end

endmodule

/* rtl/core/quadratic_min_root_unit.sv */
// quadratic_min_root_unit: pipelined smaller real root of a*x^2 + b*x + c.
// Depends on qmr_pkg, qmr_sqrt_cell and qmr_div_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries coef_a, coef_b, coef_c (signed,
//   FRAC_BITS fraction bits). Output channel out_valid/out_ready carries
//   root (signed 48-bit, FRAC_BITS fraction bits) and status:
//   0 root found, 1 no real root, 2 a is zero, 3 root saturated.
//   For status 1 and 2 root is the miss_distance register.
//   cfg_we/cfg_wdata write miss_distance; write only while idle.
//   Throughput: one word per cycle unless the output stalls. Stages from
//   input accept to output valid: three setup stages (inputs, products,
//   discriminant), 32 square root cells, two root setup stages,
//   33 + FRAC_BITS divider cells, one output register.
//   The whole pipeline advances together; when out_valid is high and
//   out_ready low, every stage holds and in_ready drops.
//   Reset clears all valid bits and loads miss_distance with
//   1000000 << FRAC_BITS.
module quadratic_min_root_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [qmr_pkg::COEF_W-1:0]   coef_a,
	input  logic signed [qmr_pkg::COEF_W-1:0]   coef_b,
	input  logic signed [qmr_pkg::COEF_W-1:0]   coef_c,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [qmr_pkg::ROOT_W-1:0]   root,
	output logic [1:0]                          status,
	input  logic                                cfg_we,
	input  logic [qmr_pkg::MISS_W-1:0]          cfg_wdata
);

	localparam int QW = qmr_pkg::NUM_W + FRAC_BITS;
	localparam logic [qmr_pkg::MISS_W-1:0] MISS_RST =
		qmr_pkg::MISS_W'(64'd1000000 << FRAC_BITS);
	localparam logic [63:0] POS_LIM = (64'd1 << (qmr_pkg::ROOT_W-1)) - 64'd1;
	localparam logic [63:0] NEG_LIM = 64'd1 << (qmr_pkg::ROOT_W-1);

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic [qmr_pkg::MISS_W-1:0] miss_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= MISS_RST;
		end else if (cfg_we) begin
			miss_q <= cfg_wdata;
		end
	end

	// setup stages
	logic v_s1, v_s2, v_s3;
	logic signed [qmr_pkg::COEF_W-1:0] a_s1, b_s1, c_s1, a_s2, b_s2;
	logic signed [63:0] bsq_s2, ac_s2, e_s3;
	qmr_pkg::sq_side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= coef_a;
			b_s1   <= coef_b;
			c_s1   <= coef_c;
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			bsq_s2 <= 64'(b_s1) * 64'(b_s1);
			ac_s2  <= 64'(a_s1) * 64'(c_s1);
			e_s3   <= (bsq_s2 >>> 2) - ac_s2;
			side_s3.a   <= a_s2;
			side_s3.b   <= b_s2;
			side_s3.rem <= bsq_s2[0];
			if (a_s2 == '0) begin
				side_s3.code <= qmr_pkg::ST_AZERO;
			end else if (((bsq_s2 >>> 2) - ac_s2) < 0) begin
				side_s3.code <= qmr_pkg::ST_NOROOT;
			end else begin
				side_s3.code <= qmr_pkg::ST_OK;
			end
		end
	end

	// square root chain
	logic                        sq_v    [0:qmr_pkg::SQ_N];
	logic [qmr_pkg::E_W-1:0]     sq_e    [0:qmr_pkg::SQ_N];
	logic [qmr_pkg::SQ_RW-1:0]   sq_r    [0:qmr_pkg::SQ_N];
	logic [qmr_pkg::SQ_N-1:0]    sq_g    [0:qmr_pkg::SQ_N];
	qmr_pkg::sq_side_t           sq_side [0:qmr_pkg::SQ_N];

	assign sq_v[0]    = v_s3;
	assign sq_e[0]    = e_s3;
	assign sq_r[0]    = '0;
	assign sq_g[0]    = '0;
	assign sq_side[0] = side_s3;

	for (genvar i = 0; i < qmr_pkg::SQ_N; i++) begin : g_sq
		qmr_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (sq_v[i]),
			.e_in    (sq_e[i]),
			.r_in    (sq_r[i]),
			.g_in    (sq_g[i]),
			.side_in (sq_side[i]),
			.v_q     (sq_v[i+1]),
			.e_q     (sq_e[i+1]),
			.r_q     (sq_r[i+1]),
			.g_q     (sq_g[i+1]),
			.side_q  (sq_side[i+1])
		);
	end

	// floor(sqrt(4e+rem)) = 2g + 1 when g + 1 - rem <= e - g*g
	logic [qmr_pkg::SQ_RW-1:0] g_lim;
	logic                      odd;
	assign g_lim = {{(qmr_pkg::SQ_RW-qmr_pkg::SQ_N){1'b0}}, sq_g[qmr_pkg::SQ_N]}
		+ qmr_pkg::SQ_RW'(1)
		- {{(qmr_pkg::SQ_RW-1){1'b0}}, sq_side[qmr_pkg::SQ_N].rem};
	assign odd = (g_lim <= sq_r[qmr_pkg::SQ_N]);

	logic                         v_s4, v_s5;
	logic [qmr_pkg::SQ_N+1:0]     s_s4;
	qmr_pkg::sq_side_t            side_s4;

	// smaller root: (-b - s)/(2a) for a > 0, (-b + s)/(2a) for a < 0
	logic signed [34:0] nb, sx, num;
	logic [31:0]        a_mag;
	assign nb    = -35'(side_s4.b);
	assign sx    = 35'({1'b0, s_s4});
	assign num   = side_s4.a[31] ? (nb + sx) : (nb - sx);
	assign a_mag = side_s4.a[31] ? (32'd0 - 32'(side_s4.a)) : 32'(side_s4.a);

	logic [qmr_pkg::NUM_W-1:0]  mag_s5;
	logic [qmr_pkg::DEN_W-1:0]  den_s5;
	qmr_pkg::dv_side_t          side_s5;
	logic [34:0]                num_abs;
	assign num_abs = num[34] ? (35'd0 - 35'(num)) : 35'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[qmr_pkg::SQ_N];
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4         <= {1'b0, sq_g[qmr_pkg::SQ_N], odd};
			side_s4      <= sq_side[qmr_pkg::SQ_N];
			mag_s5       <= num_abs[qmr_pkg::NUM_W-1:0];
			den_s5       <= {a_mag, 1'b0};
			side_s5.neg  <= num[34] ^ side_s4.a[31];
			side_s5.code <= side_s4.code;
		end
	end

	// divider chain
	logic                         dv_v    [0:QW];
	logic [QW-1:0]                dv_dvd  [0:QW];
	logic [qmr_pkg::DEN_W-1:0]    dv_den  [0:QW];
	logic [qmr_pkg::DIV_RW-1:0]   dv_r    [0:QW];
	logic [QW-1:0]                dv_q    [0:QW];
	qmr_pkg::dv_side_t            dv_side [0:QW];

	assign dv_v[0]    = v_s5;
	assign dv_dvd[0]  = {mag_s5, {FRAC_BITS{1'b0}}};
	assign dv_den[0]  = den_s5;
	assign dv_r[0]    = '0;
	assign dv_q[0]    = '0;
	assign dv_side[0] = side_s5;

	for (genvar j = 0; j < QW; j++) begin : g_dv
		qmr_div_cell #(.QW(QW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.v_in    (dv_v[j]),
			.dvd_in  (dv_dvd[j]),
			.den_in  (dv_den[j]),
			.r_in    (dv_r[j]),
			.q_in    (dv_q[j]),
			.side_in (dv_side[j]),
			.v_q     (dv_v[j+1]),
			.dvd_q   (dv_dvd[j+1]),
			.den_q   (dv_den[j+1]),
			.r_q     (dv_r[j+1]),
			.q_q     (dv_q[j+1]),
			.side_q  (dv_side[j+1])
		);
	end

	// sign, saturation and status
	logic [63:0] qx;
	assign qx = 64'(dv_q[QW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_side[QW].code != qmr_pkg::ST_OK) begin
				root   <= $signed({1'b0, miss_q});
				status <= dv_side[QW].code;
			end else if (!dv_side[QW].neg) begin
				if (qx > POS_LIM) begin
					root   <= $signed(POS_LIM[qmr_pkg::ROOT_W-1:0]);
					status <= qmr_pkg::ST_SAT;
				end else begin
					root   <= $signed(qx[qmr_pkg::ROOT_W-1:0]);
					status <= qmr_pkg::ST_OK;
				end
			end else begin
				if (qx > NEG_LIM) begin
					root   <= $signed(NEG_LIM[qmr_pkg::ROOT_W-1:0]);
					status <= qmr_pkg::ST_SAT;
				end else begin
					root   <= $signed(qmr_pkg::ROOT_W'(64'd0 - qx));
					status <= qmr_pkg::ST_OK;
				end
			end
		end
	end

endmodule

/* rtl/core/qmr_checker.sv */
// qmr_checker: port-level assertions for quadratic_min_root_unit.
// Depends on qmr_pkg; bound to the top level below.
module qmr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [qmr_pkg::ROOT_W-1:0]   root,
	input logic [1:0]                          status
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root) && $stable(status))
		else $error("stalled output word changed");

	// an empty output slot never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// input stalls only behind a stalled output
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// saturated roots sit at a rail
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == qmr_pkg::ST_SAT |->
			root == {1'b0, {(qmr_pkg::ROOT_W-1){1'b1}}} ||
			root == {1'b1, {(qmr_pkg::ROOT_W-1){1'b0}}})
		else $error("saturated root off the rail");

endmodule

bind quadratic_min_root_unit qmr_checker u_qmr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.root      (root),
	.status    (status)
);

/* tb/qmr_checker.sv */
// qmr_tb_checker: watches both channels of quadratic_min_root_unit, predicts each
// result and compares it against the output word. Depends on qmr_pkg.
module qmr_tb_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [qmr_pkg::COEF_W-1:0] coef_a,
	input  logic signed [qmr_pkg::COEF_W-1:0] coef_b,
	input  logic signed [qmr_pkg::COEF_W-1:0] coef_c,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [qmr_pkg::ROOT_W-1:0] root,
	input  logic [1:0]                        status,
	input  logic                              cfg_we,
	input  logic [qmr_pkg::MISS_W-1:0]        cfg_wdata,
	output int                                fails,
	output int                                pending
);

	typedef struct packed {
		logic signed [qmr_pkg::ROOT_W-1:0] root;
		logic [1:0]                        status;
	} root_word_t;

	localparam longint ROOT_HI = 64'sd140737488355327;
	localparam longint ROOT_LO = -64'sd140737488355328;

	root_word_t                 root_q[$];
	logic [qmr_pkg::MISS_W-1:0] miss_dist;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > n)
			bt = bt >> 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// (num << FRAC_BITS) / den, truncated toward zero
	function automatic longint frac_quot(longint num, longint den);
		longint unsigned mn, md, q;
		logic neg;
		neg = (num < 0) != (den < 0);
		mn = (num < 0) ? -num : num;
		md = (den < 0) ? -den : den;
		q = (mn << FRAC_BITS) / md;
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic root_word_t min_root(longint a, longint b, longint c,
			logic [qmr_pkg::MISS_W-1:0] miss);
		root_word_t w;
		longint bsq, qtr, e, s, r0, r1, rt;
		longint unsigned rem, g;
		w.status = qmr_pkg::ST_OK;
		w.root = {1'b0, miss};
		if (a == 0) begin
			w.status = qmr_pkg::ST_AZERO;
			return w;
		end
		bsq = b * b;
		qtr = bsq >>> 2;
		rem = bsq & 3;
		e = qtr - a * c;
		if (e < 0) begin
			w.status = qmr_pkg::ST_NOROOT;
			return w;
		end
		g = int_sqrt(e);
		s = 2 * g;
		if (g * (g + 1) + 1 - rem <= longint'(e))
			s = s + 1;
		r0 = frac_quot(-b + s, 2 * a);
		r1 = frac_quot(-b - s, 2 * a);
		rt = (r0 < r1) ? r0 : r1;
		if (rt > ROOT_HI) begin
			rt = ROOT_HI;
			w.status = qmr_pkg::ST_SAT;
		end else if (rt < ROOT_LO) begin
			rt = ROOT_LO;
			w.status = qmr_pkg::ST_SAT;
		end
		w.root = rt[qmr_pkg::ROOT_W-1:0];
		return w;
	endfunction

	assign pending = root_q.size();

	always @(posedge clk or negedge arst_n) begin
		root_word_t exp_w;
		if (!arst_n) begin
			miss_dist <= qmr_pkg::MISS_W'(64'd1000000 << FRAC_BITS);
			fails <= 0;
			root_q.delete();
		end else begin
			if (cfg_we)
				miss_dist <= cfg_wdata;
			if (in_valid && in_ready)
				root_q.push_back(min_root(coef_a, coef_b, coef_c, miss_dist));
			if (out_valid && out_ready) begin
				if (root_q.size() == 0) begin
					$error("output word with nothing expected: root %0d status %0d",
						root, status);
					fails <= fails + 1;
				end else begin
					exp_w = root_q.pop_front();
					if (root !== exp_w.root || status !== exp_w.status) begin
						if (root !== exp_w.root)
							$error("root: expected %0d, got %0d", exp_w.root, root);
						if (status !== exp_w.status)
							$error("status: expected %0d, got %0d",
								exp_w.status, status);
						fails <= fails + 1;
					end
				end
			end
		end
	end

endmodule

/* tb/quadratic_min_root_unit_tb.sv */
// quadratic_min_root_unit_tb: drives coefficient words and register writes
// into quadratic_min_root_unit; qmr_tb_checker does the checking. Needs qmr_pkg.
module quadratic_min_root_unit_tb;

	localparam int FRAC_BITS = 16;
	localparam int LAT = 71 + FRAC_BITS;
	localparam int LIMIT = 400000;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [qmr_pkg::COEF_W-1:0] coef_a = '0;
	logic signed [qmr_pkg::COEF_W-1:0] coef_b = '0;
	logic signed [qmr_pkg::COEF_W-1:0] coef_c = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [qmr_pkg::ROOT_W-1:0] root;
	logic [1:0]                        status;
	logic                              cfg_we = 1'b0;
	logic [qmr_pkg::MISS_W-1:0]        cfg_wdata = '0;
	int                                fails;
	int                                pending;
	int                                tx_idle = 0;
	int                                rx_idle = 0;
	int                                cycles = 0;

	always #1 clk = ~clk;

	quadratic_min_root_unit #(.FRAC_BITS(FRAC_BITS)) u_top (.*);
	qmr_tb_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** quadratic_min_root_unit: FAILED **");
			$finish;
		end
	end

	task automatic send_word(logic [31:0] a, logic [31:0] b, logic [31:0] c);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain the pipeline, then write miss distance while idle
	task automatic drain_and_write(logic [qmr_pkg::MISS_W-1:0] val);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LAT + 8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_word();
		logic [31:0] a, b, c;
		a = $urandom;
		b = $urandom;
		c = $urandom;
		case ($urandom_range(4))
			0: ;  // full range
			1: begin  // small coefficients, real roots likely
				a = $signed(a) >>> $urandom_range(31, 8);
				b = $signed(b) >>> $urandom_range(31, 4);
				c = $signed(c) >>> $urandom_range(31, 8);
			end
			2: begin  // a and c mostly of opposite sign: real roots likely
				a = $signed(a) >>> $urandom_range(31, 0);
				c = $signed(c) >>> $urandom_range(31, 0);
				if (a[31] == c[31]) c = -c;
			end
			3: a = $signed(a) >>> $urandom_range(31, 28);  // tiny a, saturation
			default: if ($urandom_range(3) == 0) a = 0;
		endcase
		send_word(a, b, c);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, a zero, negative and zero discriminant, a root at the negative rail
		send_word(32'h0, 32'h0001_0000, 32'h0001_0000);
		send_word(32'h0, 32'h8000_0000, 32'h7fff_ffff);
		send_word(32'h0001_0000, 32'h0, 32'h0001_0000);
		send_word(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
		send_word(32'h0001_0000, 32'h0, 32'hffff_0000);
		send_word(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
		send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_word(32'h0000_0001, 32'h8000_0000, 32'h0);
		send_word(32'h0000_0001, 32'h7fff_ffff, 32'h0);
		send_word(32'hffff_ffff, 32'h8000_0000, 32'h0);
		send_word(32'hffff_ffff, 32'h7fff_ffff, 32'h0);
		send_word(32'h0000_0001, 32'h0, 32'h8000_0000);
		send_word(32'hffff_ffff, 32'h0, 32'h7fff_ffff);
		send_word(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff);
		send_word(32'h7fff_ffff, 32'h0, 32'h0);
		send_word(32'h8000_0000, 32'h0000_0003, 32'h0);

		drain_and_write('0);
		tx_idle = 37;
		rx_idle = 68;
		repeat (300) random_word();

		drain_and_write({qmr_pkg::MISS_W{1'b1}});
		tx_idle = 68;
		rx_idle = 37;
		repeat (150) random_word();
		drain_and_write(qmr_pkg::MISS_W'({$urandom, $urandom}));
		repeat (150) random_word();

		drain_and_write(qmr_pkg::MISS_W'($urandom));
		tx_idle = 0;
		rx_idle = 0;
		repeat (300) random_word();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LAT + 20) @(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("** quadratic_min_root_unit: PASSED **");
		end else begin
			$display("** quadratic_min_root_unit: FAILED **");
		end
		$finish;
	end

endmodule
